### design/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
`timescale 1ns / 1ps
package rmq_pkg;

    localparam int DATA_W     = 32;
    localparam int WIDE_W     = 64;
    localparam int MAG_W      = 31;
    localparam int SQRT_STEPS = 32;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 34;

    typedef logic signed [DATA_W-1:0] elem_t;
    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        logic [3:0] neg;
        logic       degen;
    } flags_t;

    typedef struct packed {
        flags_t          f;
        logic [3:0][MAG_W-1:0] mg;
    } side_t;

endpackage

### design/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix (Q1.FRAC_BITS) to renormalized unit quaternion.
//
// Usage: present the nine matrix elements with in_valid; a beat is taken when
// in_valid and in_ready are both high. Results leave on out_valid/out_ready as
// quat_w..quat_z plus the degenerate flag, which marks an identity fallback
// when the chosen branch has a non-positive square-root argument.
// The pipeline takes one matrix per cycle unless the receiver stalls. A beat
// passes through six front stages (branch, magnitudes, leading-one search,
// normalize shift, squares, sum), a 32-stage square root that retires one
// root bit per stage, a divider that retires one quotient bit per stage for
// all four components at once, and the output register.
// All stages advance together whenever the output register is empty or being
// read, so in_ready follows out_ready; while the receiver stalls, every beat
// in flight holds its place and nothing is lost or repeated.
// Reset clears all valid bits; the block comes out of reset empty and ready.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion
#(
    parameter int FRAC_BITS = 30
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rmq_pkg::elem_t       m00,
    input  rmq_pkg::elem_t       m01,
    input  rmq_pkg::elem_t       m02,
    input  rmq_pkg::elem_t       m10,
    input  rmq_pkg::elem_t       m11,
    input  rmq_pkg::elem_t       m12,
    input  rmq_pkg::elem_t       m20,
    input  rmq_pkg::elem_t       m21,
    input  rmq_pkg::elem_t       m22,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rmq_pkg::elem_t       quat_w,
    output rmq_pkg::elem_t       quat_x,
    output rmq_pkg::elem_t       quat_y,
    output rmq_pkg::elem_t       quat_z,
    output logic                 degenerate
);
    import rmq_pkg::*;

    localparam int QW = FRAC_BITS + 2;
    localparam logic signed [WIDE_W-1:0] ONE = WIDE_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] OUT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] ONE_SAT = (FRAC_BITS >= 31) ? OUT_MAX : ONE[DATA_W-1:0];

    logic en;
    logic out_valid_reg;

    // Stage 1: branch selection.
    logic                            s1_vld_reg;
    logic signed [WIDE_W-1:0]        s1_v_reg [4];
    logic signed [WIDE_W-1:0]        s1_d_reg;
    logic signed [WIDE_W-1:0]        s1_v_next [4];
    logic signed [WIDE_W-1:0]        s1_d_next;

    always_comb
    begin
        logic signed [WIDE_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, tr;
        a00 = WIDE_W'(m00); a01 = WIDE_W'(m01); a02 = WIDE_W'(m02);
        a10 = WIDE_W'(m10); a11 = WIDE_W'(m11); a12 = WIDE_W'(m12);
        a20 = WIDE_W'(m20); a21 = WIDE_W'(m21); a22 = WIDE_W'(m22);
        tr  = a00 + a11 + a22;
        if (tr > 0)
        begin
            s1_d_next    = tr + ONE;
            s1_v_next[0] = s1_d_next;
            s1_v_next[1] = a21 - a12;
            s1_v_next[2] = a02 - a20;
            s1_v_next[3] = a10 - a01;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            s1_d_next    = ONE + a00 - a11 - a22;
            s1_v_next[0] = a21 - a12;
            s1_v_next[1] = s1_d_next;
            s1_v_next[2] = a01 + a10;
            s1_v_next[3] = a02 + a20;
        end
        else if (a11 > a22)
        begin
            s1_d_next    = ONE + a11 - a00 - a22;
            s1_v_next[0] = a02 - a20;
            s1_v_next[1] = a01 + a10;
            s1_v_next[2] = s1_d_next;
            s1_v_next[3] = a12 + a21;
        end
        else
        begin
            s1_d_next    = ONE + a22 - a00 - a11;
            s1_v_next[0] = a10 - a01;
            s1_v_next[1] = a02 + a20;
            s1_v_next[2] = a12 + a21;
            s1_v_next[3] = s1_d_next;
        end
    end

    // Stage 2: magnitudes, signs, largest magnitude.
    logic                     s2_vld_reg;
    logic [WIDE_W-1:0]        s2_mg_reg [4];
    logic [WIDE_W-1:0]        s2_mx_reg;
    flags_t                   s2_f_reg;
    logic [WIDE_W-1:0]        s2_mg_next [4];
    logic [WIDE_W-1:0]        s2_mx_next;
    flags_t                   s2_f_next;

    always_comb
    begin
        logic [WIDE_W-1:0] m01x, m23x;
        for (int l = 0; l < 4; l++)
        begin
            s2_f_next.neg[l] = s1_v_reg[l][WIDE_W-1];
            s2_mg_next[l]    = s1_v_reg[l][WIDE_W-1] ? WIDE_W'(-s1_v_reg[l])
                                                     : WIDE_W'(s1_v_reg[l]);
        end
        m01x = (s2_mg_next[0] > s2_mg_next[1]) ? s2_mg_next[0] : s2_mg_next[1];
        m23x = (s2_mg_next[2] > s2_mg_next[3]) ? s2_mg_next[2] : s2_mg_next[3];
        s2_mx_next = (m01x > m23x) ? m01x : m23x;
        s2_f_next.degen = (s1_d_reg <= 0);
    end

    // Stage 3: leading-one position of the largest magnitude.
    logic                     s3_vld_reg;
    logic [WIDE_W-1:0]        s3_mg_reg [4];
    logic [5:0]               s3_p_reg;
    flags_t                   s3_f_reg;
    logic [5:0]               s3_p_next;

    always_comb
    begin
        s3_p_next = '0;
        for (int i = 0; i < WIDE_W; i++)
        begin
            if (s2_mx_reg[i])
                s3_p_next = 6'(i);
        end
    end

    // Stage 4: shift so the largest magnitude lands in [2^30, 2^31).
    logic                     s4_vld_reg;
    side_t                    s4_side_reg;
    side_t                    s4_side_next;

    always_comb
    begin
        logic [WIDE_W-1:0] sh;
        s4_side_next.f = s3_f_reg;
        for (int l = 0; l < 4; l++)
        begin
            if (s3_p_reg >= 6'(MAG_W))
                sh = s3_mg_reg[l] >> (s3_p_reg - 6'(MAG_W - 1));
            else
                sh = s3_mg_reg[l] << (6'(MAG_W - 1) - s3_p_reg);
            s4_side_next.mg[l] = sh[MAG_W-1:0];
        end
    end

    // Stage 5: squares. Stage 6: sum of squares.
    logic                     s5_vld_reg;
    logic [2*MAG_W-1:0]       s5_sq_reg [4];
    side_t                    s5_side_reg;
    logic                     s6_vld_reg;
    logic [WIDE_W-1:0]        s6_sum_reg;
    side_t                    s6_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_d_reg    <= s1_d_next;
            s2_mx_reg   <= s2_mx_next;
            s2_f_reg    <= s2_f_next;
            s3_p_reg    <= s3_p_next;
            s3_f_reg    <= s2_f_reg;
            s4_side_reg <= s4_side_next;
            s5_side_reg <= s4_side_reg;
            s6_side_reg <= s5_side_reg;
            s6_sum_reg  <= WIDE_W'(s5_sq_reg[0]) + WIDE_W'(s5_sq_reg[1])
                         + WIDE_W'(s5_sq_reg[2]) + WIDE_W'(s5_sq_reg[3]);
            for (int l = 0; l < 4; l++)
            begin
                s1_v_reg[l]  <= s1_v_next[l];
                s2_mg_reg[l] <= s2_mg_next[l];
                s3_mg_reg[l] <= s2_mg_reg[l];
                s5_sq_reg[l] <= s4_side_reg.mg[l] * s4_side_reg.mg[l];
            end
        end
    end

    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    side_t             sq_side;

    rmq_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s6_vld_reg),
        .radicand (s6_sum_reg),
        .in_side  (s6_side_reg),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .out_side (sq_side)
    );

    logic                  dv_vld;
    logic [3:0][QW-1:0]    dv_q;
    flags_t                dv_f;

    rmq_fdiv #(.FRAC_BITS(FRAC_BITS)) u_fdiv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (sq_vld),
        .divisor   (sq_root),
        .dividend  (sq_side.mg),
        .in_flags  (sq_side.f),
        .out_vld   (dv_vld),
        .quot      (dv_q),
        .out_flags (dv_f)
    );

    // Output register: round, saturate, restore sign; degenerate beats get the identity.
    logic [DATA_W-1:0] q_next [4];
    logic [DATA_W-1:0] q_reg  [4];
    logic              degen_reg;

    always_comb
    begin
        logic [WIDE_W:0]   rnd;
        logic [DATA_W-1:0] mag;
        for (int l = 0; l < 4; l++)
        begin
            rnd = (WIDE_W'(dv_q[l]) + (WIDE_W+1)'(1)) >> 1;
            mag = (rnd > (WIDE_W+1)'(OUT_MAX)) ? OUT_MAX : rnd[DATA_W-1:0];
            q_next[l] = dv_f.neg[l] ? DATA_W'(-mag) : mag;
        end
        if (dv_f.degen)
        begin
            q_next[0] = ONE_SAT;
            q_next[1] = '0;
            q_next[2] = '0;
            q_next[3] = '0;
        end
    end

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            degen_reg <= dv_f.degen;
            for (int l = 0; l < 4; l++)
                q_reg[l] <= q_next[l];
        end
    end

    assign out_valid  = out_valid_reg;
    assign quat_w     = q_reg[0];
    assign quat_x     = q_reg[1];
    assign quat_y     = q_reg[2];
    assign quat_z     = q_reg[3];
    assign degenerate = degen_reg;

endmodule

### design/rmq_isqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
`timescale 1ns / 1ps
module rmq_isqrt
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_vld,
    input  logic [rmq_pkg::WIDE_W-1:0]       radicand,
    input  rmq_pkg::side_t                   in_side,
    output logic                             out_vld,
    output logic [rmq_pkg::ROOT_W-1:0]       root,
    output rmq_pkg::side_t                   out_side
);
    import rmq_pkg::*;

    logic [SQRT_STEPS-1:0]        vld_reg;
    logic [WIDE_W-1:0]            a_reg    [SQRT_STEPS];
    logic [WIDE_W-1:0]            res_reg  [SQRT_STEPS];
    side_t                        side_reg [SQRT_STEPS];
    logic [WIDE_W-1:0]            a_next   [SQRT_STEPS];
    logic [WIDE_W-1:0]            res_next [SQRT_STEPS];

    always_comb
    begin
        logic [WIDE_W-1:0] a_in;
        logic [WIDE_W-1:0] r_in;
        logic [WIDE_W-1:0] bitv;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            a_in = (k == 0) ? radicand : a_reg[(k == 0) ? 0 : k-1];
            r_in = (k == 0) ? '0 : res_reg[(k == 0) ? 0 : k-1];
            bitv = WIDE_W'(1) << (WIDE_W - 2 - 2*k);
            if (a_in >= r_in + bitv)
            begin
                a_next[k]   = a_in - (r_in + bitv);
                res_next[k] = (r_in >> 1) + bitv;
            end
            else
            begin
                a_next[k]   = a_in;
                res_next[k] = r_in >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[SQRT_STEPS-2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                a_reg[k]    <= a_next[k];
                res_reg[k]  <= res_next[k];
                side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign out_vld  = vld_reg[SQRT_STEPS-1];
    assign root     = res_reg[SQRT_STEPS-1][ROOT_W-1:0];
    assign out_side = side_reg[SQRT_STEPS-1];

endmodule

### design/rmq_fdiv.sv
// Pipelined restoring divider for four lanes: m * 2^(FRAC_BITS+1) / n, one bit per stage.
`timescale 1ns / 1ps
module rmq_fdiv
#(
    parameter int FRAC_BITS = 30
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_vld,
    input  logic [rmq_pkg::ROOT_W-1:0]        divisor,
    input  logic [3:0][rmq_pkg::MAG_W-1:0]    dividend,
    input  rmq_pkg::flags_t                   in_flags,
    output logic                              out_vld,
    output logic [3:0][FRAC_BITS+1:0]         quot,
    output rmq_pkg::flags_t                   out_flags
);
    import rmq_pkg::*;

    localparam int NST = FRAC_BITS + 2;
    localparam int QW  = FRAC_BITS + 2;

    logic [NST-1:0]              vld_reg;
    logic [ROOT_W-1:0]           n_reg     [NST];
    logic [3:0][REM_W-1:0]       rem_reg   [NST];
    logic [3:0][QW-1:0]          q_reg     [NST];
    flags_t                      flags_reg [NST];
    logic [3:0][REM_W-1:0]       rem_next  [NST];
    logic [3:0][QW-1:0]          q_next    [NST];

    always_comb
    begin
        logic [REM_W-1:0] r;
        logic [QW-1:0]    q;
        logic [REM_W-1:0] nd;
        for (int k = 0; k < NST; k++)
        begin
            for (int l = 0; l < 4; l++)
            begin
                if (k == 0)
                begin
                    nd = REM_W'(divisor);
                    r  = REM_W'(dividend[l]);
                    q  = '0;
                end
                else
                begin
                    nd = REM_W'(n_reg[(k == 0) ? 0 : k-1]);
                    r  = rem_reg[(k == 0) ? 0 : k-1][l] << 1;
                    q  = q_reg[(k == 0) ? 0 : k-1][l] << 1;
                end
                if (r >= nd)
                begin
                    r    = r - nd;
                    q[0] = 1'b1;
                end
                rem_next[k][l] = r;
                q_next[k][l]   = q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NST; k++)
            begin
                rem_reg[k]   <= rem_next[k];
                q_reg[k]     <= q_next[k];
                n_reg[k]     <= (k == 0) ? divisor : n_reg[(k == 0) ? 0 : k-1];
                flags_reg[k] <= (k == 0) ? in_flags : flags_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign out_vld   = vld_reg[NST-1];
    assign quot      = q_reg[NST-1];
    assign out_flags = flags_reg[NST-1];

endmodule
